// ----- rtl/lsag_pkg.sv -----
// Shared types and constants of the LED strip animation generator.
// No dependencies; imported by lsag_div and led_strip_animation_generator_unit.
`default_nettype none

package lsag_pkg;

  localparam int unsigned MaxPixels = 64;
  localparam int unsigned PixW      = $clog2(MaxPixels);
  localparam int unsigned CntW      = $clog2(MaxPixels + 1);
  localparam int unsigned QuotW     = 8;
  localparam int unsigned PhaseW    = 11;
  localparam int unsigned PhaseWrap = 256 * 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ANIM_MODE      = 2'd0,
    CFG_FRAME_INTERVAL = 2'd1,
    CFG_PIXEL_COUNT    = 2'd2,
    CFG_CHASE_COLOR    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_FIXED   = 2'd0,
    MODE_CHASE   = 2'd1,
    MODE_RAINBOW = 2'd2,
    MODE_SPARE   = 2'd3
  } anim_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic            start;
    logic [PixW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ----- rtl/led_strip_animation_generator_unit.sv -----
// Top level of the LED strip animation generator: frame timing, pixel sequencer, output register.
// Depends on lsag_pkg and lsag_div.
`default_nettype none

// Each input beat carries the millisecond time. In theater chase or rainbow mode, once
// now - last frame time reaches frame_interval_ms, one frame is sent: one output beat per
// pixel, pixel 0 first, frame_end on the last. A beat that starts no frame is not stalled.
// A chase frame needs no divider; in rainbow mode each pixel waits for the shared divider
// that forms p*256/count one quotient bit per cycle. Input stall stays high until the frame
// has been handed to the output register. Write configuration only while idle.
module led_strip_animation_generator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lsag_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lsag_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [31:0]                      now_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [5:0]                       pixel_index_o,
  output logic [7:0]                       red_o,
  output logic [7:0]                       green_o,
  output logic [7:0]                       blue_o,
  output logic                             frame_end_o
);
  import lsag_pkg::*;

  // configuration
  logic [1:0]          mode_q;
  logic [15:0]         interval_q;
  logic [CntW-1:0]     pix_cnt_q;
  logic [23:0]         chase_color_q;

  // state
  seq_state_e          state_q, state_d;
  logic [31:0]         last_ms_q, last_ms_d;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [1:0]          offset_q, offset_d;
  logic [PixW-1:0]     pix_q, pix_d;
  logic [1:0]          mod3_q, mod3_d;
  logic [CntW-1:0]     count;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [PixW-1:0]     out_pix_q;
  logic [7:0]          out_r_q, out_g_q, out_b_q;
  logic                out_end_q;

  logic                in_beat, animated, due, load, last_pix;
  logic [31:0]         elapsed;
  div_req_t            div_req;
  logic                div_done;
  logic [QuotW-1:0]    quot;
  logic [7:0]          wheel_pos, v, vs;
  logic [7:0]          pix_r, pix_g, pix_b;
  logic [9:0]          v3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_FIXED;
      interval_q    <= 16'd150;
      pix_cnt_q     <= CntW'(46);
      chase_color_q <= 24'h7F7F7F;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANIM_MODE:      mode_q        <= cfg_data_i[1:0];
        CFG_FRAME_INTERVAL: interval_q    <= cfg_data_i[15:0];
        CFG_PIXEL_COUNT:    pix_cnt_q     <= cfg_data_i[CntW-1:0];
        CFG_CHASE_COLOR:    chase_color_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign count    = (pix_cnt_q > CntW'(MaxPixels)) ? CntW'(MaxPixels) : pix_cnt_q;
  assign elapsed  = now_ms_i - last_ms_q;
  assign animated = (mode_q == MODE_CHASE) || (mode_q == MODE_RAINBOW);
  assign due      = elapsed >= {16'd0, interval_q};
  assign in_beat  = in_valid_i && !in_stall_o;
  assign last_pix = ({1'b0, pix_q} + 1'b1) == count;
  assign load     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // wheel color
  assign wheel_pos = quot + phase_q[7:0];
  assign v         = 8'd255 - wheel_pos;
  always_comb begin
    vs = v;
    if (v < 8'd85) begin
      vs = v;
    end else if (v < 8'd170) begin
      vs = v - 8'd85;
    end else begin
      vs = v - 8'd170;
    end
  end
  assign v3 = {2'b00, vs} + {1'b0, vs, 1'b0};

  always_comb begin
    pix_r = 8'd0;
    pix_g = 8'd0;
    pix_b = 8'd0;
    if (mode_q == MODE_CHASE) begin
      if (mod3_q == offset_q) begin
        pix_r = chase_color_q[23:16];
        pix_g = chase_color_q[15:8];
        pix_b = chase_color_q[7:0];
      end
    end else if (v < 8'd85) begin
      pix_r = 8'd255 - v3[7:0];
      pix_b = v3[7:0];
    end else if (v < 8'd170) begin
      pix_g = v3[7:0];
      pix_b = 8'd255 - v3[7:0];
    end else begin
      pix_r = v3[7:0];
      pix_g = 8'd255 - v3[7:0];
    end
  end

  always_comb begin
    state_d          = state_q;
    last_ms_d        = last_ms_q;
    phase_d          = phase_q;
    offset_d         = offset_q;
    pix_d            = pix_q;
    mod3_d           = mod3_q;
    div_req.start    = 1'b0;
    div_req.dividend = pix_q;
    div_req.divisor  = count;
    in_stall_o       = state_q != ST_IDLE;
    out_valid_d      = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_beat && animated && due) begin
          last_ms_d = now_ms_i;
          pix_d     = '0;
          mod3_d    = 2'd0;
          if (count == '0) begin
            if (mode_q == MODE_CHASE) begin
              offset_d = (offset_q == 2'd2) ? 2'd0 : offset_q + 2'd1;
            end else begin
              phase_d = (phase_q == PhaseW'(PhaseWrap - 1)) ? '0 : phase_q + 1'b1;
            end
          end else if (mode_q == MODE_RAINBOW) begin
            div_req.start    = 1'b1;
            div_req.dividend = '0;
            state_d          = ST_DIV;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (last_pix) begin
            state_d = ST_IDLE;
            if (mode_q == MODE_CHASE) begin
              offset_d = (offset_q == 2'd2) ? 2'd0 : offset_q + 2'd1;
            end else begin
              phase_d = (phase_q == PhaseW'(PhaseWrap - 1)) ? '0 : phase_q + 1'b1;
            end
          end else begin
            pix_d  = pix_q + 1'b1;
            mod3_d = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
            if (mode_q == MODE_RAINBOW) begin
              div_req.start    = 1'b1;
              div_req.dividend = pix_q + 1'b1;
              state_d          = ST_DIV;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_ms_q   <= '0;
      phase_q     <= '0;
      offset_q    <= '0;
      pix_q       <= '0;
      mod3_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_ms_q   <= last_ms_d;
      phase_q     <= phase_d;
      offset_q    <= offset_d;
      pix_q       <= pix_d;
      mod3_q      <= mod3_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_pix_q <= pix_q;
      out_r_q   <= pix_r;
      out_g_q   <= pix_g;
      out_b_q   <= pix_b;
      out_end_q <= last_pix;
    end
  end

  lsag_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_pix_q;
  assign red_o         = out_r_q;
  assign green_o       = out_g_q;
  assign blue_o        = out_b_q;
  assign frame_end_o   = out_end_q;

endmodule

`default_nettype wire

// ----- rtl/lsag_div.sv -----
// Restoring divider: (pixel << 8) / count, one quotient bit per cycle.
// Depends on lsag_pkg. Requires dividend < divisor, so the quotient fits 8 bits.
`default_nettype none

module lsag_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lsag_pkg::div_req_t                   req_i,
  output logic                                 done_o,
  output logic [lsag_pkg::QuotW-1:0]           quot_o
);
  import lsag_pkg::*;

  localparam int unsigned StepW = $clog2(QuotW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [CntW-1:0]     rem_q, rem_d;
  logic [CntW-1:0]     dvs_q, dvs_d;
  logic [QuotW-1:0]    quot_q, quot_d;
  logic [CntW:0]       shifted;
  logic                fits;

  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = CntW'(req_i.dividend);
      dvs_d  = req_i.divisor;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = fits ? CntW'(shifted - {1'b0, dvs_q}) : CntW'(shifted);
      quot_d = {quot_q[QuotW-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == StepW'(QuotW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- tb/lsag_frame_checker.sv -----
// Scoreboard for the LED strip animation generator: predicts the pixel beats of each frame.
// Watches the config port and both channels; depends on lsag_pkg.
`timescale 1ns / 1ps

module lsag_frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsag_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsag_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [31:0]                   now_ms_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [5:0]                    pixel_index_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic                          frame_end_i,
  output int                            mismatch_cnt_o,
  output int                            pending_o,
  output int                            pixels_checked_o,
  output int                            frames_checked_o
);
  import lsag_pkg::*;

  typedef struct packed {
    logic [5:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_beat_t;

  pixel_beat_t       expected_pixels[$];

  anim_mode_e        mode_q;
  logic [15:0]       interval_q;
  logic [6:0]        count_q;
  logic [23:0]       color_q;
  logic [31:0]       last_frame_ms;
  logic [PhaseW-1:0] rainbow_phase;
  logic [1:0]        chase_offset;

  function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
    int         v;
    logic [7:0] r, g, b;
    v = 255 - int'(pos);
    if (v < 85) begin
      r = 8'(255 - 3 * v); g = 8'd0; b = 8'(3 * v);
    end else if (v < 170) begin
      v = v - 85;
      r = 8'd0; g = 8'(3 * v); b = 8'(255 - 3 * v);
    end else begin
      v = v - 170;
      r = 8'(3 * v); g = 8'(255 - 3 * v); b = 8'd0;
    end
    return {r, g, b};
  endfunction

  task automatic predict_frame(input logic [31:0] now);
    logic [31:0] elapsed;
    logic [23:0] rgb;
    logic [7:0]  pos;
    pixel_beat_t beat;
    int          n;
    if (mode_q != MODE_CHASE && mode_q != MODE_RAINBOW) return;
    elapsed = now - last_frame_ms;
    if (elapsed < {16'd0, interval_q}) return;
    last_frame_ms = now;
    n = (int'(count_q) > int'(MaxPixels)) ? int'(MaxPixels) : int'(count_q);
    for (int p = 0; p < n; p++) begin
      if (mode_q == MODE_CHASE) begin
        rgb = (p % 3 == int'(chase_offset)) ? color_q : 24'h0;
      end else begin
        pos = 8'((p * 256) / n + int'(rainbow_phase));
        rgb = wheel_rgb(pos);
      end
      beat.idx   = 6'(p);
      beat.red   = rgb[23:16];
      beat.green = rgb[15:8];
      beat.blue  = rgb[7:0];
      beat.last  = (p == n - 1);
      expected_pixels.push_back(beat);
    end
    if (mode_q == MODE_CHASE) begin
      chase_offset = (chase_offset == 2'd2) ? 2'd0 : chase_offset + 2'd1;
    end else begin
      rainbow_phase = (rainbow_phase == PhaseW'(PhaseWrap - 1)) ? '0 : rainbow_phase + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_beat_t got;
    pixel_beat_t want;
    if (!rst_ni) begin
      expected_pixels.delete();
      mode_q           = MODE_FIXED;
      interval_q       = 16'd150;
      count_q          = 7'd46;
      color_q          = 24'h7F7F7F;
      last_frame_ms    = '0;
      rainbow_phase    = '0;
      chase_offset     = '0;
      mismatch_cnt_o   = 0;
      pending_o        = 0;
      pixels_checked_o = 0;
      frames_checked_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {pixel_index_i, red_i, green_i, blue_i, frame_end_i};
        if (expected_pixels.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("%0t: unexpected pixel beat idx=%0d rgb=%02h%02h%02h last=%0b",
                     $time, got.idx, got.red, got.green, got.blue, got.last);
          mismatch_cnt_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (mismatch_cnt_o < 10)
              $display({"%0t: pixel beat mismatch: expected idx=%0d rgb=%02h%02h%02h last=%0b,",
                        " got idx=%0d rgb=%02h%02h%02h last=%0b"},
                       $time, want.idx, want.red, want.green, want.blue, want.last,
                       got.idx, got.red, got.green, got.blue, got.last);
            mismatch_cnt_o++;
          end
        end
        pixels_checked_o++;
        if (got.last) frames_checked_o++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ANIM_MODE:      mode_q     = anim_mode_e'(cfg_data_i[1:0]);
          CFG_FRAME_INTERVAL: interval_q = cfg_data_i[15:0];
          CFG_PIXEL_COUNT:    count_q    = cfg_data_i[6:0];
          CFG_CHASE_COLOR:    color_q    = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_frame(now_ms_i);
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ----- tb/led_strip_animation_generator_unit_test.sv -----
// Testbench top for led_strip_animation_generator_unit: clock, reset, config and time beats.
// Depends on lsag_pkg, the block, and lsag_frame_checker for prediction and comparison.
`timescale 1ns / 1ps

module led_strip_animation_generator_unit_test;
  import lsag_pkg::*;

  localparam int CycleLimit = 3_000_000;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic [31:0]         now_ms_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [5:0]          pixel_index_o;
  logic [7:0]          red_o, green_o, blue_o;
  logic                frame_end_o;

  int mismatches, pending_pixels, pixels_checked, frames_checked;
  int idle_pct  = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int cycles = 0;

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  led_strip_animation_generator_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .now_ms_i,
    .out_valid_o, .out_stall_i, .pixel_index_o, .red_o, .green_o, .blue_o, .frame_end_o
  );

  lsag_frame_checker frame_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .now_ms_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .pixel_index_i(pixel_index_o), .red_i(red_o), .green_i(green_o), .blue_i(blue_o),
    .frame_end_i(frame_end_o),
    .mismatch_cnt_o(mismatches), .pending_o(pending_pixels),
    .pixels_checked_o(pixels_checked), .frames_checked_o(frames_checked)
  );

  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // upper bits beyond each register are randomized; the block must drop them
  task automatic set_regs(input anim_mode_e mode, input logic [15:0] interval,
                          input logic [6:0] count, input logic [23:0] color);
    logic [23:0] d;
    d = 24'($urandom_range(24'hFFFFFF)); d[1:0]  = mode;     write_reg(CFG_ANIM_MODE, d);
    d = 24'($urandom_range(24'hFFFFFF)); d[15:0] = interval; write_reg(CFG_FRAME_INTERVAL, d);
    d = 24'($urandom_range(24'hFFFFFF)); d[6:0]  = count;    write_reg(CFG_PIXEL_COUNT, d);
    write_reg(CFG_CHASE_COLOR, color);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_time(input logic [31:0] t);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    now_ms_i   <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // drain all pixel beats, then let a frame without output settle
  task automatic close_batch();
    in_valid_i <= 1'b0;
    while (pending_pixels != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    anim_mode_e  mode;
    int          ivl;
    int          cnt;
    int          pick;
    logic [31:0] tnow;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fixed mode after reset: nothing out
    send_time(32'd1000);
    close_batch();

    // chase, zero interval, offset rotation through a wrap of the time stamp
    set_regs(MODE_CHASE, 16'd0, 7'd5, 24'hFFFFFF);
    send_time(32'd0);
    send_time(32'hFFFFFFFF);
    send_time(32'd0);
    send_time(32'd7);
    close_batch();

    // max interval, saturated count, black color
    set_regs(MODE_CHASE, 16'hFFFF, 7'd65, 24'h000000);
    send_time(32'd65541);
    send_time(32'd65542);
    send_time(32'hFFFFFFF0);
    close_batch();

    // rainbow, full strip, interval hit exactly across the wrap
    set_regs(MODE_RAINBOW, 16'd16, 7'd64, 24'h5A00A5);
    send_time(32'd0);
    send_time(32'h0000000F);
    send_time(32'h00000010);
    close_batch();

    set_regs(MODE_RAINBOW, 16'd0, 7'd127, 24'hA5005A);
    send_time(32'hFFFFFFFF);
    send_time(32'h80000000);
    close_batch();

    // zero pixels: time and phase still advance
    set_regs(MODE_RAINBOW, 16'd0, 7'd0, 24'h000000);
    send_time(32'h55555555);
    send_time(32'hAAAAAAAA);
    close_batch();
    set_regs(MODE_RAINBOW, 16'd0, 7'd3, 24'h000000);
    send_time(32'h12345678);
    close_batch();

    // spare mode is silent; chase offset is kept across mode changes
    set_regs(MODE_SPARE, 16'd0, 7'd5, 24'hFFFFFF);
    send_time(32'hDEADBEEF);
    close_batch();
    set_regs(MODE_CHASE, 16'd0, 7'd2, 24'h123456);
    send_time(32'd0);
    close_batch();

    // advance the rainbow phase with empty frames
    set_regs(MODE_RAINBOW, 16'd0, 7'd0, 24'h000000);
    repeat (20) send_time($urandom);
    close_batch();
    set_regs(MODE_RAINBOW, 16'd0, 7'd4, 24'h000000);
    repeat (3) send_time($urandom);
    close_batch();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      pick = $urandom_range(9);
      mode = anim_mode_e'((pick == 0) ? MODE_FIXED : (pick == 1) ? MODE_SPARE :
                          (pick < 6) ? MODE_CHASE : MODE_RAINBOW);
      ivl  = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(40);
      pick = $urandom_range(19);
      cnt  = (pick == 0) ? 0 : (pick == 1) ? 64 : (pick == 2) ? $urandom_range(65, 127) :
             $urandom_range(1, 12);
      set_regs(mode, 16'(ivl), 7'(cnt), 24'($urandom_range(24'hFFFFFF)));
      tnow = $urandom;
      for (int k = 0; k < 18; k++) begin
        if ($urandom_range(9) == 0) begin
          send_time($urandom);
        end else begin
          tnow = tnow + $urandom_range(2 * ivl + 2);
          send_time(tnow);
        end
      end
      close_batch();
    end

    $display("run: %0d time beats, %0d pixel beats in %0d frames checked",
             beats_sent, pixels_checked, frames_checked);
    $display("run: all modes, pixel counts 0..127, empty frames, idle/stall mixes");
    if (mismatches == 0 && pending_pixels == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
